// File: src/tpt_pkg.sv
package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 256;

  localparam int TLB_W   = $clog2(TLB_ENTRIES);
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int CNT_W   = $clog2(PAGE_COUNT + 1);
  localparam int NF_W    = $clog2(FRAME_COUNT + 1);
  localparam int FRAME_W = 8;
  localparam int OFF_W   = 8;
  localparam int VA_W    = 16;
  localparam int CTR_W   = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_PT_READ,
    S_VSCAN,
    S_VMAP,
    S_EVICT,
    S_TSCAN,
    S_TWRITE,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_PAGE,
    RD_SCAN,
    RD_VICTIM
  } rd_sel_e;

  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    logic    tlb_hit_upd;
    logic    pt_hit;
    logic    load_free;
    logic    scan_start;
    logic    scan_step;
    logic    evict;
    logic    tscan_start;
    logic    tscan_step;
    logic    twrite;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic tlb_match;
    logic resident;
    logic free_avail;
    logic vscan_done;
    logic tscan_done;
    logic out_free;
  } sts_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    logic [CTR_W-1:0] r;
    r = (v == '1) ? v : v + CTR_W'(1);
    return r;
  endfunction

  // reduce page number modulo PAGE_COUNT by restoring subtraction
  function automatic logic [PAGE_W-1:0] page_wrap(input logic [7:0] p);
    logic [16:0] v;
    logic [16:0] m;
    v = {9'd0, p};
    for (int k = 7; k >= 0; k--) begin
      m = 17'(PAGE_COUNT) << k;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[PAGE_W-1:0];
  endfunction

endpackage

// File: src/tpt_ram.sv
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tpt_ctrl.sv
module tpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tpt_pkg::sts_t sts_i,
  output tpt_pkg::cmd_t cmd_o
);

  tpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.rd_sel = tpt_pkg::RD_PAGE;
    case (state_q)
      tpt_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = tpt_pkg::S_LOOKUP;
        end
      end
      tpt_pkg::S_LOOKUP: begin
        cmd_o.rd_sel = tpt_pkg::RD_PAGE;
        if (sts_i.tlb_match) begin
          cmd_o.tlb_hit_upd = 1'b1;
          state_d = tpt_pkg::S_DONE;
        end else if (sts_i.resident) begin
          state_d = tpt_pkg::S_PT_READ;
        end else if (sts_i.free_avail) begin
          cmd_o.load_free   = 1'b1;
          cmd_o.tscan_start = 1'b1;
          state_d = tpt_pkg::S_TSCAN;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = tpt_pkg::S_VSCAN;
        end
      end
      tpt_pkg::S_PT_READ: begin
        cmd_o.pt_hit      = 1'b1;
        cmd_o.tscan_start = 1'b1;
        state_d = tpt_pkg::S_TSCAN;
      end
      tpt_pkg::S_VSCAN: begin
        cmd_o.rd_sel    = tpt_pkg::RD_SCAN;
        cmd_o.scan_step = 1'b1;
        if (sts_i.vscan_done) begin
          state_d = tpt_pkg::S_VMAP;
        end
      end
      tpt_pkg::S_VMAP: begin
        cmd_o.rd_sel = tpt_pkg::RD_VICTIM;
        state_d = tpt_pkg::S_EVICT;
      end
      tpt_pkg::S_EVICT: begin
        cmd_o.evict       = 1'b1;
        cmd_o.tscan_start = 1'b1;
        state_d = tpt_pkg::S_TSCAN;
      end
      tpt_pkg::S_TSCAN: begin
        cmd_o.tscan_step = 1'b1;
        if (sts_i.tscan_done) begin
          state_d = tpt_pkg::S_TWRITE;
        end
      end
      tpt_pkg::S_TWRITE: begin
        cmd_o.twrite = 1'b1;
        state_d = tpt_pkg::S_DONE;
      end
      tpt_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = tpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tpt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: src/tpt_dp.sv
module tpt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [tpt_pkg::VA_W-1:0]      virtual_addr_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [tpt_pkg::VA_W-1:0]      phys_addr_o,
  output logic                          tlb_hit_o,
  output logic                          pg_fault_o,
  input  tpt_pkg::cmd_t                 cmd_i,
  output tpt_pkg::sts_t                 sts_o
);

  localparam int N  = tpt_pkg::TLB_ENTRIES;
  localparam int TW = tpt_pkg::TLB_W;
  localparam int PW = tpt_pkg::PAGE_W;
  localparam int CW = tpt_pkg::CTR_W;
  localparam int FW = tpt_pkg::FRAME_W;

  logic                     mode_q;
  logic [PW-1:0]            page_q;
  logic [tpt_pkg::OFF_W-1:0] offset_q;
  logic [FW-1:0]            frame_q, frame_d;
  logic                     hit_q, fault_q;
  logic [tpt_pkg::NF_W-1:0] next_free_q;
  logic [CW-1:0]            access_q;
  logic [tpt_pkg::PAGE_COUNT-1:0] resident_q;

  logic [N-1:0]  t_valid_q;
  logic [PW-1:0] t_page_q  [N];
  logic [FW-1:0] t_frame_q [N];
  logic [CW-1:0] t_uses_q  [N];
  logic [CW-1:0] t_time_q  [N];

  logic [N-1:0]  tmatch, tvmatch;
  logic [TW-1:0] thit_idx;

  logic [tpt_pkg::CNT_W-1:0] vcnt_q;
  logic                      vpend_q, vhave_q;
  logic [PW-1:0]             vpidx_q, vbest_q;
  logic [CW-1:0]             vbest_m_q, vmetric;
  logic                      vtake;

  logic [TW-1:0] tcnt_q, tbest_q;
  logic          tinv_q, thave_q;
  logic [CW-1:0] tbest_m_q, tmetric;

  logic [PW-1:0] raddr;
  logic [FW-1:0] map_rdata;
  logic [CW-1:0] cnt_rdata, stamp_rdata;
  logic          map_we, cnt_we, stamp_we;
  logic [CW-1:0] cnt_wdata;

  logic out_valid_q;
  logic [tpt_pkg::VA_W-1:0] out_addr_q;
  logic out_hit_q, out_fault_q;

  always_comb begin
    thit_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      tmatch[i]  = t_valid_q[i] && (t_page_q[i] == page_q);
      tvmatch[i] = t_valid_q[i] && (t_page_q[i] == vbest_q);
      if (tmatch[i]) begin
        thit_idx = TW'(i);
      end
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      tpt_pkg::RD_PAGE:   raddr = page_q;
      tpt_pkg::RD_SCAN:   raddr = vcnt_q[PW-1:0];
      tpt_pkg::RD_VICTIM: raddr = vbest_q;
      default:            raddr = page_q;
    endcase
  end

  always_comb begin
    frame_d = frame_q;
    if (cmd_i.tlb_hit_upd) begin
      frame_d = t_frame_q[thit_idx];
    end else if (cmd_i.pt_hit) begin
      frame_d = map_rdata;
    end else if (cmd_i.load_free) begin
      frame_d = FW'(next_free_q);
    end else if (cmd_i.evict) begin
      frame_d = vhave_q ? map_rdata : '0;
    end
  end

  assign map_we    = cmd_i.load_free || cmd_i.evict;
  assign stamp_we  = map_we;
  assign cnt_we    = map_we || cmd_i.pt_hit;
  assign cnt_wdata = cmd_i.pt_hit ? tpt_pkg::sat_inc(cnt_rdata) : CW'(1);

  tpt_ram #(.WIDTH(FW), .DEPTH(tpt_pkg::PAGE_COUNT)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (page_q),
    .wdata_i (frame_d),
    .raddr_i (raddr),
    .rdata_o (map_rdata)
  );

  tpt_ram #(.WIDTH(CW), .DEPTH(tpt_pkg::PAGE_COUNT)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (page_q),
    .wdata_i (cnt_wdata),
    .raddr_i (raddr),
    .rdata_o (cnt_rdata)
  );

  tpt_ram #(.WIDTH(CW), .DEPTH(tpt_pkg::PAGE_COUNT)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (page_q),
    .wdata_i (access_q),
    .raddr_i (raddr),
    .rdata_o (stamp_rdata)
  );

  // victim page scan
  assign vmetric = mode_q ? stamp_rdata : cnt_rdata;
  assign vtake   = vpend_q && resident_q[vpidx_q] && (!vhave_q || vmetric < vbest_m_q);

  // tlb refill scan
  assign tmetric = mode_q ? t_time_q[tcnt_q] : t_uses_q[tcnt_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      next_free_q <= '0;
      access_q    <= '0;
      resident_q  <= '0;
      t_valid_q   <= '0;
      vpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.load_free) begin
        next_free_q <= next_free_q + tpt_pkg::NF_W'(1);
        resident_q[page_q] <= 1'b1;
      end
      if (cmd_i.evict) begin
        if (vhave_q) begin
          resident_q[vbest_q] <= 1'b0;
          t_valid_q <= t_valid_q & ~tvmatch;
        end
        resident_q[page_q] <= 1'b1;
      end
      if (cmd_i.twrite) begin
        t_valid_q[tbest_q] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        vpend_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        vpend_q <= vcnt_q < tpt_pkg::CNT_W'(tpt_pkg::PAGE_COUNT);
      end
      if (cmd_i.finish) begin
        access_q    <= tpt_pkg::sat_inc(access_q);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q   <= tpt_pkg::page_wrap(virtual_addr_i[tpt_pkg::VA_W-1:tpt_pkg::OFF_W]);
      offset_q <= virtual_addr_i[tpt_pkg::OFF_W-1:0];
      hit_q    <= 1'b0;
      fault_q  <= 1'b0;
    end
    if (cmd_i.tlb_hit_upd) begin
      hit_q <= 1'b1;
      t_uses_q[thit_idx] <= tpt_pkg::sat_inc(t_uses_q[thit_idx]);
    end
    if (cmd_i.load_free || cmd_i.evict) begin
      fault_q <= 1'b1;
    end
    frame_q <= frame_d;

    if (cmd_i.scan_start) begin
      vcnt_q  <= '0;
      vhave_q <= 1'b0;
    end else begin
      if (cmd_i.scan_step && vcnt_q < tpt_pkg::CNT_W'(tpt_pkg::PAGE_COUNT)) begin
        vcnt_q <= vcnt_q + tpt_pkg::CNT_W'(1);
      end
      if (vtake) begin
        vhave_q   <= 1'b1;
        vbest_q   <= vpidx_q;
        vbest_m_q <= vmetric;
      end
    end
    vpidx_q <= vcnt_q[PW-1:0];

    if (cmd_i.tscan_start) begin
      tcnt_q  <= '0;
      tinv_q  <= 1'b0;
      thave_q <= 1'b0;
    end else if (cmd_i.tscan_step) begin
      tcnt_q <= tcnt_q + TW'(1);
      if (!tinv_q) begin
        if (!t_valid_q[tcnt_q]) begin
          tinv_q  <= 1'b1;
          tbest_q <= tcnt_q;
        end else if (!thave_q || tmetric < tbest_m_q) begin
          thave_q   <= 1'b1;
          tbest_q   <= tcnt_q;
          tbest_m_q <= tmetric;
        end
      end
    end

    if (cmd_i.twrite) begin
      t_page_q[tbest_q]  <= page_q;
      t_frame_q[tbest_q] <= frame_q;
      t_uses_q[tbest_q]  <= CW'(1);
      t_time_q[tbest_q]  <= access_q;
    end

    if (cmd_i.finish) begin
      out_addr_q  <= {frame_q, offset_q};
      out_hit_q   <= hit_q;
      out_fault_q <= fault_q;
    end
  end

  assign sts_o.tlb_match  = |tmatch;
  assign sts_o.resident   = resident_q[page_q];
  assign sts_o.free_avail = next_free_q < tpt_pkg::NF_W'(tpt_pkg::FRAME_COUNT);
  assign sts_o.vscan_done = vpend_q && (vpidx_q == PW'(tpt_pkg::PAGE_COUNT - 1));
  assign sts_o.tscan_done = tcnt_q == TW'(N - 1);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = out_addr_q;
  assign tlb_hit_o   = out_hit_q;
  assign pg_fault_o  = out_fault_q;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= tpt_pkg::NF_W'(tpt_pkg::FRAME_COUNT))
    else $error("free frame pointer past frame count");

  a_tlb_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tmatch) <= 1)
    else $error("page held by more than one tlb entry");

  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> vhave_q)
    else $error("eviction without resident victim");
`endif

endmodule

// File: src/tlb_page_table_translator.sv
// Translates one 16-bit virtual address per word (page in bits 15..8, offset in 7..0)
// into a physical address, with a tlb hit flag and a page fault flag. A miss reads the
// page table RAMs, or takes the next free frame on a fault, and then refills the tlb by
// stepping over its TLB_ENTRIES entries one per cycle; a fault once all frames are taken
// first scans all PAGE_COUNT pages through the use count and load stamp RAMs one per
// cycle. One word is in work at a time; the next is accepted while the previous result
// still waits at the output. replacement_mode 0 picks victims by least use, 1 by earliest
// load; write it only while the block is idle.
module tlb_page_table_translator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tpt_pkg::VA_W-1:0]      virtual_addr_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tpt_pkg::VA_W-1:0]      phys_addr_o,
  output logic                          tlb_hit_o,
  output logic                          pg_fault_o
);

  tpt_pkg::cmd_t cmd;
  tpt_pkg::sts_t sts;

  tpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .virtual_addr_i  (virtual_addr_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .phys_addr_o     (phys_addr_o),
    .tlb_hit_o       (tlb_hit_o),
    .pg_fault_o      (pg_fault_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: verif/tb_top.sv
class xlate_scoreboard;
  logic [7:0]  tlb_page [16];
  bit          tlb_vld [16];
  logic [7:0]  tlb_frm [16];
  logic [31:0] tlb_uses [16];
  logic [31:0] tlb_ins [16];
  logic [7:0]  pg_frame [256];
  bit          pg_res [256];
  logic [31:0] pg_uses [256];
  logic [31:0] pg_stamp [256];
  int unsigned free_frame;
  logic [31:0] clock_now;
  bit          mode;
  logic [17:0] pending_q [$];
  int          errors;
  int          hits;
  int          faults;

  function new();
    for (int i = 0; i < 16; i++) begin
      tlb_page[i] = 0; tlb_vld[i] = 0; tlb_frm[i] = 0; tlb_uses[i] = 0; tlb_ins[i] = 0;
    end
    for (int i = 0; i < 256; i++) begin
      pg_frame[i] = 0; pg_res[i] = 0; pg_uses[i] = 0; pg_stamp[i] = 0;
    end
    free_frame = 0;
    clock_now = 0;
    mode = 0;
    errors = 0;
    hits = 0;
    faults = 0;
  endfunction

  function logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function void note_word(logic [15:0] va);
    logic [7:0]  pg;
    logic [7:0]  frm;
    logic [31:0] now;
    bit          hit;
    bit          flt;
    int          t;
    int          v;
    int          pos;
    pg = va[15:8];
    now = clock_now;
    hit = 0;
    flt = 0;
    t = -1;
    for (int i = 0; i < 16; i++) begin
      if (t < 0 && tlb_vld[i] && tlb_page[i] == pg) t = i;
    end
    if (t >= 0) begin
      frm = tlb_frm[t];
      tlb_uses[t] = bump(tlb_uses[t]);
      hit = 1;
    end else begin
      if (pg_res[pg]) begin
        frm = pg_frame[pg];
        pg_uses[pg] = bump(pg_uses[pg]);
      end else begin
        flt = 1;
        if (free_frame < 256) begin
          frm = free_frame[7:0];
          free_frame++;
        end else begin
          v = -1;
          for (int i = 0; i < 256; i++) begin
            if (pg_res[i]) begin
              if (v < 0) v = i;
              else if (!mode && pg_uses[i] < pg_uses[v]) v = i;
              else if (mode && pg_stamp[i] < pg_stamp[v]) v = i;
            end
          end
          frm = 0;
          if (v >= 0) begin
            frm = pg_frame[v];
            pg_res[v] = 0;
            pg_uses[v] = 0;
            pg_stamp[v] = 0;
            for (int i = 0; i < 16; i++) begin
              if (tlb_vld[i] && tlb_page[i] == v[7:0]) tlb_vld[i] = 0;
            end
          end
        end
        pg_frame[pg] = frm;
        pg_res[pg] = 1;
        pg_uses[pg] = 1;
        pg_stamp[pg] = now;
      end
      pos = -1;
      for (int i = 0; i < 16; i++) begin
        if (pos < 0 && !tlb_vld[i]) pos = i;
      end
      if (pos < 0) begin
        pos = 0;
        for (int i = 1; i < 16; i++) begin
          if (!mode && tlb_uses[i] < tlb_uses[pos]) pos = i;
          if (mode && tlb_ins[i] < tlb_ins[pos]) pos = i;
        end
      end
      tlb_page[pos] = pg;
      tlb_frm[pos] = frm;
      tlb_vld[pos] = 1;
      tlb_uses[pos] = 1;
      tlb_ins[pos] = now;
    end
    clock_now = bump(clock_now);
    hits += hit;
    faults += flt;
    pending_q.push_back({frm, va[7:0], hit, flt});
  endfunction

  function void check_word(logic [15:0] pa, logic hit, logic flt);
    logic [17:0] e;
    if (pending_q.size() == 0) begin
      $error("unexpected result word pa=%h", pa);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (pa !== e[17:2]) begin
      $error("phys_addr expected %h actual %h", e[17:2], pa);
      errors++;
    end
    if (hit !== e[1]) begin
      $error("tlb_hit expected %b actual %b", e[1], hit);
      errors++;
    end
    if (flt !== e[0]) begin
      $error("pg_fault expected %b actual %b", e[0], flt);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] virtual_addr_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] phys_addr_o;
  logic        tlb_hit_o;
  logic        pg_fault_o;

  xlate_scoreboard sb;
  int  idle_cycles;
  int  words_sent;
  bit  fast_phase;

  tlb_page_table_translator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .virtual_addr_i (virtual_addr_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .phys_addr_o    (phys_addr_o),
    .tlb_hit_o      (tlb_hit_o),
    .pg_fault_o     (pg_fault_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_word(logic [15:0] va);
    int gap;
    gap = fast_phase ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    virtual_addr_i <= va;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(va);
    words_sent++;
  endtask

  task automatic write_mode(bit m);
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.mode = m;
  endtask

  // receiver with random stall
  initial begin
    int st;
    out_stall_i = 1;
    @(posedge rst_ni);
    forever begin
      st = fast_phase ? 0 : $urandom_range(0, 19);
      if (st > 0) begin
        out_stall_i <= 1;
        repeat (st) @(posedge clk_i);
      end
      out_stall_i <= 0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_word(phys_addr_o, tlb_hit_o, pg_fault_o);
    end
  end

  // watchdog on progress
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("tlb_page_table_translator test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] pg;
    sb = new();
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    in_valid_i = 0;
    virtual_addr_i = 0;
    words_sent = 0;
    fast_phase = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, tlb hit, page table hit after tlb thrash
    send_word(16'h0000);
    send_word(16'hffff);
    send_word(16'h00ff);
    send_word(16'hff00);
    send_word(16'haa55);
    send_word(16'h55aa);
    for (int i = 1; i <= 17; i++) send_word({i[7:0], 8'h3c});
    send_word(16'h0012);
    send_word(16'hff81);
    // fill all frames, lfu mode
    for (int i = 0; i < 256; i++) begin
      fast_phase = (i % 64) < 40;
      send_word({i[7:0], 8'($urandom_range(0, 255))});
    end
    fast_phase = 0;
    for (int i = 0; i < 300; i++) begin
      pg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 23));
      send_word({pg, 8'($urandom_range(0, 255))});
    end
    write_mode(1);
    for (int i = 0; i < 300; i++) begin
      fast_phase = (i % 100) < 20;
      pg = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 31));
      send_word({pg, 8'($urandom_range(0, 255))});
    end
    fast_phase = 0;
    write_mode(0);
    for (int i = 0; i < 100; i++) begin
      send_word({8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))});
    end
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("sent %0d words, %0d tlb hits, %0d page faults", words_sent, sb.hits, sb.faults);
    $display("both replacement modes exercised with random gaps and stalls");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tlb_page_table_translator test passed");
    end else begin
      $display("tlb_page_table_translator test failed");
    end
    $finish;
  end
endmodule

// File: tlb_page_table_translator.f
src/tpt_pkg.sv
src/tpt_ram.sv
src/tpt_ctrl.sv
src/tpt_dp.sv
src/tlb_page_table_translator.sv
verif/tb_top.sv
